[rtl/bqac_pkg.sv]
package bqac_pkg;

  localparam logic [1:0] OP_ALLOW  = 2'd0;
  localparam logic [1:0] OP_CHARGE = 2'd1;
  localparam logic [1:0] OP_DENY   = 2'd2;

  localparam logic [1:0] SCOPE_NONE       = 2'd0;
  localparam logic [1:0] SCOPE_PRINCIPAL  = 2'd1;
  localparam logic [1:0] SCOPE_CONNECTION = 2'd2;
  localparam logic [1:0] SCOPE_RESERVED   = 2'd3;

  localparam logic [63:0] BYTES_UNLIMITED = '1;

  typedef struct packed {
    logic [1:0]  operation;
    logic        admitted;
    logic [7:0]  owner_slot;
    logic [63:0] stream_limit;
    logic [63:0] principal_limit;
    logic [63:0] stream_used;
    logic [63:0] amount;
    logic [1:0]  current_scope;
    logic [1:0]  deny_scope;
  } item_t;

  typedef struct packed {
    logic [63:0] allowance;
    logic [1:0]  limit_scope;
    logic [63:0] new_stream_used;
    logic [1:0]  new_scope;
    logic        denied;
    logic [31:0] denial_count;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [63:0] data;
  } total_wr_t;

endpackage

[rtl/byte_quota_allowance_and_charge.sv]
// Channel   Handshake            Payload
// command   start_i / busy_o     operation_i .. deny_scope_i
// result    done_o (one cycle)   allowance_o .. denial_count_o
// config    active_principals_we_i  active_principals_i
//
// One item is taken every cycle; its result is registered in s1 and then in the output stage.
// This depth is set by the principal table read-modify-write: registered RAM read
// in the accept cycle, update in the next, with a bypass for back-to-back charges.
// Reset clears the denial counter, the per-entry valid bits and active_principals;
// an entry never written reads as zero, so no clearing pass is needed.
// busy_o stays low and results cannot be held off.
module byte_quota_allowance_and_charge import bqac_pkg::*; #(
  parameter int PRINCIPALS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic        admitted_i,
  input  logic [7:0]  owner_slot_i,
  input  logic [63:0] stream_limit_i,
  input  logic [63:0] principal_limit_i,
  input  logic [63:0] stream_used_i,
  input  logic [63:0] amount_i,
  input  logic [1:0]  current_scope_i,
  input  logic [1:0]  deny_scope_i,
  input  logic        active_principals_we_i,
  input  logic [4:0]  active_principals_i,
  output logic        done_o,
  output logic [63:0] allowance_o,
  output logic [1:0]  limit_scope_o,
  output logic [63:0] new_stream_used_o,
  output logic [1:0]  new_scope_o,
  output logic        denied_o,
  output logic [31:0] denial_count_o
);

  localparam int         AW      = (PRINCIPALS > 1) ? $clog2(PRINCIPALS) : 1;
  localparam logic [8:0] PRIN_LIM = 9'(PRINCIPALS);

  logic            accept;
  item_t           item_d;
  item_t           s1_item_q;
  logic            s1_valid_q;
  logic [4:0]      active_q;
  logic [31:0]     denials_q;
  logic [31:0]     denials_d;
  logic            valid_q [PRINCIPALS];
  logic            fwd_valid_q;
  logic [AW-1:0]   fwd_addr_q;
  logic [63:0]     fwd_data_q;
  logic [AW-1:0]   s1_addr;
  logic            in_range;
  logic            controlled;
  logic            entry_hit;
  logic [63:0]     ram_rdata;
  logic [63:0]     total;
  logic            ram_we;
  result_t         result_d;
  result_t         result_q;
  total_wr_t       total_wr;
  logic            done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign item_d = '{
    operation:       operation_i,
    admitted:        admitted_i,
    owner_slot:      owner_slot_i,
    stream_limit:    stream_limit_i,
    principal_limit: principal_limit_i,
    stream_used:     stream_used_i,
    amount:          amount_i,
    current_scope:   current_scope_i,
    deny_scope:      deny_scope_i
  };

  bqac_ram #(
    .WIDTH (64),
    .DEPTH (PRINCIPALS)
  ) u_totals (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (total_wr.data),
    .raddr_i (owner_slot_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign s1_addr    = s1_item_q.owner_slot[AW-1:0];
  assign in_range   = {1'b0, s1_item_q.owner_slot} < PRIN_LIM;
  assign controlled = s1_item_q.admitted && in_range
                      && (s1_item_q.owner_slot < {3'b000, active_q});
  assign entry_hit  = in_range && valid_q[s1_addr];

  always_comb begin
    // take the total just written over the stale RAM read
    if (fwd_valid_q && fwd_addr_q == s1_addr) begin
      total = fwd_data_q;
    end else if (entry_hit) begin
      total = ram_rdata;
    end else begin
      total = '0;
    end
  end

  bqac_calc u_calc (
    .item_i       (s1_item_q),
    .controlled_i (controlled),
    .total_i      (total),
    .denials_i    (denials_q),
    .result_o     (result_d),
    .total_wr_o   (total_wr),
    .denials_o    (denials_d)
  );

  assign ram_we = s1_valid_q && total_wr.we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      done_q      <= 1'b0;
      active_q    <= '0;
      denials_q   <= '0;
      fwd_valid_q <= 1'b0;
      for (int i = 0; i < PRINCIPALS; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      s1_valid_q  <= accept;
      done_q      <= s1_valid_q;
      fwd_valid_q <= ram_we;
      if (active_principals_we_i) begin
        active_q <= active_principals_i;
      end
      if (s1_valid_q) begin
        denials_q <= denials_d;
      end
      if (ram_we) begin
        valid_q[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_d;
    end
    if (s1_valid_q) begin
      result_q <= result_d;
    end
    if (ram_we) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= total_wr.data;
    end
  end

  assign done_o            = done_q;
  assign allowance_o       = result_q.allowance;
  assign limit_scope_o     = result_q.limit_scope;
  assign new_stream_used_o = result_q.new_stream_used;
  assign new_scope_o       = result_q.new_scope;
  assign denied_o          = result_q.denied;
  assign denial_count_o    = result_q.denial_count;

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item produced no result strobe");

  a_count_only_on_deny : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(denials_q) |-> $past(s1_valid_q && s1_item_q.operation == OP_DENY))
    else $error("denial counter moved without a deny item");

  a_write_only_charge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (s1_item_q.operation == OP_CHARGE && controlled))
    else $error("principal table written outside a controlled charge");

  a_deny_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_item_q.operation == OP_DENY) |=> (done_o && denied_o))
    else $error("deny item did not mark the connection denied");

endmodule

[rtl/bqac_ram.sv]
module bqac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bqac_calc.sv]
module bqac_calc import bqac_pkg::*; (
  input  item_t       item_i,
  input  logic        controlled_i,
  input  logic [63:0] total_i,
  input  logic [31:0] denials_i,
  output result_t     result_o,
  output total_wr_t   total_wr_o,
  output logic [31:0] denials_o
);

  logic [63:0] stream_left;
  logic [63:0] principal_left;
  logic [64:0] used_sum;
  logic [64:0] total_sum;

  always_comb begin
    // zero limit reads as unlimited
    if (item_i.stream_limit == '0) begin
      stream_left = BYTES_UNLIMITED;
    end else if (item_i.stream_used >= item_i.stream_limit) begin
      stream_left = '0;
    end else begin
      stream_left = item_i.stream_limit - item_i.stream_used;
    end

    if (item_i.principal_limit == '0) begin
      principal_left = BYTES_UNLIMITED;
    end else if (total_i >= item_i.principal_limit) begin
      principal_left = '0;
    end else begin
      principal_left = item_i.principal_limit - total_i;
    end

    used_sum  = {1'b0, item_i.stream_used} + {1'b0, item_i.amount};
    total_sum = {1'b0, total_i} + {1'b0, item_i.amount};
  end

  always_comb begin
    result_o.allowance       = '0;
    result_o.limit_scope     = SCOPE_NONE;
    result_o.new_stream_used = item_i.stream_used;
    result_o.new_scope       = item_i.current_scope;
    result_o.denied          = 1'b0;
    total_wr_o.we            = 1'b0;
    total_wr_o.data          = total_sum[64] ? BYTES_UNLIMITED : total_sum[63:0];
    denials_o                = denials_i;

    case (item_i.operation)
      OP_ALLOW: begin
        if (!controlled_i) begin
          result_o.allowance = BYTES_UNLIMITED;
        end else if (item_i.principal_limit != '0 && principal_left <= stream_left) begin
          result_o.allowance   = principal_left;
          result_o.limit_scope = SCOPE_PRINCIPAL;
        end else if (item_i.stream_limit != '0) begin
          result_o.allowance   = stream_left;
          result_o.limit_scope = SCOPE_CONNECTION;
        end else begin
          result_o.allowance = BYTES_UNLIMITED;
        end
      end
      OP_CHARGE: begin
        if (item_i.amount != '0 && controlled_i) begin
          result_o.new_stream_used = used_sum[64] ? BYTES_UNLIMITED : used_sum[63:0];
          total_wr_o.we            = 1'b1;
        end
      end
      OP_DENY: begin
        // count only the first denial; a reserved scope records as connection
        if (item_i.current_scope == SCOPE_NONE) begin
          result_o.new_scope = (item_i.deny_scope == SCOPE_RESERVED) ? SCOPE_CONNECTION
                                                                     : item_i.deny_scope;
          denials_o          = denials_i + 32'd1;
        end
        result_o.denied = 1'b1;
      end
      default: begin
      end
    endcase

    result_o.denial_count = denials_o;
  end

endmodule
